/* sv/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants of the radix digit converter: the sequencer
// states, the conversion mode codes and helpers that classify a mode.
// ----------------------------------------------------------------------------
package rdc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_DECODE,
    ST_ENCODE,
    ST_FINISH
  } rdc_state_t;

  typedef logic [2:0] rdc_mode_t;

  localparam rdc_mode_t MODE_BIN2VAL = 3'd0;
  localparam rdc_mode_t MODE_VAL2BIN = 3'd1;
  localparam rdc_mode_t MODE_OCT2VAL = 3'd2;
  localparam rdc_mode_t MODE_VAL2OCT = 3'd3;
  localparam rdc_mode_t MODE_BIN2OCT = 3'd4;
  localparam rdc_mode_t MODE_OCT2BIN = 3'd5;

  function automatic logic mode_decodes(input rdc_mode_t m);
    return (m == MODE_BIN2VAL) || (m == MODE_OCT2VAL) ||
           (m == MODE_BIN2OCT) || (m == MODE_OCT2BIN);
  endfunction

  function automatic logic mode_encodes(input rdc_mode_t m);
    return (m == MODE_VAL2BIN) || (m == MODE_VAL2OCT) ||
           (m == MODE_BIN2OCT) || (m == MODE_OCT2BIN);
  endfunction

  function automatic logic src_is_oct(input rdc_mode_t m);
    return (m == MODE_OCT2VAL) || (m == MODE_OCT2BIN);
  endfunction

  function automatic logic dst_is_oct(input rdc_mode_t m);
    return (m == MODE_VAL2OCT) || (m == MODE_BIN2OCT);
  endfunction

endpackage

/* sv/radix_digit_converter_unit.sv */
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// A digit-coded source is decoded by binary to BCD shifting, then one decimal
// digit at a time, stopping at an invalid digit; encoding shifts out one target
// digit at a time (binary or octal); a finish state then loads the result.
// One item at a time: a new transfer is taken only in idle, after the result
// is loaded; a stalled output holds the finish state.
// Reset (synchronous, rst_n low) returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
module radix_digit_converter_unit
  import rdc_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_mode,
  input  logic [VALUE_BITS-1:0] in_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_result,
  output logic                  out_invalid_digit,
  output logic                  out_overflow
);

  localparam int DIGITS = (VALUE_BITS * 31) / 100 + 1;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int SH_W   = 3 * ((VALUE_BITS + 2) / 3);
  localparam int CW     = $clog2(SH_W);
  localparam int PW     = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] VAL_MAX = '1;

  rdc_state_t            state_r, state_nxt;
  rdc_mode_t             mode_r, mode_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [SH_W-1:0]       enc_r, enc_nxt;
  logic [VALUE_BITS-1:0] cod_r, cod_nxt;
  logic                  bad_r, bad_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_result_r, out_result_nxt;
  logic                  out_bad_r, out_bad_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            dec_digit;
  logic                  dec_bad;
  logic [VALUE_BITS-1:0] dec_acc;
  logic [2:0]            enc_digit;
  logic [PW-1:0]         cod_ext;
  logic [PW-1:0]         cod_prod;
  logic                  cod_over;
  logic                  out_free;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                    : bcd_r[4*i +: 4];
    end
  end

  assign dec_digit = bcd_r[BCD_W-1 -: 4];
  assign dec_bad   = src_is_oct(mode_r) ? dec_digit[3] : (dec_digit[3:1] != 3'd0);
  assign dec_acc   = src_is_oct(mode_r) ? {acc_r[VALUE_BITS-4:0], dec_digit[2:0]}
                                        : {acc_r[VALUE_BITS-2:0], dec_digit[0]};

  assign enc_digit = dst_is_oct(mode_r) ? enc_r[SH_W-1 -: 3] : {2'b00, enc_r[SH_W-1]};
  assign cod_ext   = {4'b0000, cod_r};
  assign cod_prod  = (cod_ext << 3) + (cod_ext << 1) + PW'(enc_digit);
  assign cod_over  = (cod_prod[PW-1:VALUE_BITS] != 4'd0);

  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode_decodes(in_mode)) begin
            state_nxt = ST_DABBLE;
          end else if (mode_encodes(in_mode)) begin
            state_nxt = ST_ENCODE;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_DABBLE: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (dec_bad) begin
          state_nxt = ST_FINISH;
        end else if (cnt_r == '0) begin
          state_nxt = mode_encodes(mode_r) ? ST_ENCODE : ST_FINISH;
        end
      end
      ST_ENCODE: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    bin_nxt        = bin_r;
    bcd_nxt        = bcd_r;
    acc_nxt        = acc_r;
    enc_nxt        = enc_r;
    cod_nxt        = cod_r;
    bad_nxt        = bad_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;
    out_bad_nxt    = out_bad_r;
    out_ovf_nxt    = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_mode;
          bad_nxt  = 1'b0;
          ovf_nxt  = 1'b0;
          acc_nxt  = '0;
          cod_nxt  = '0;
          bin_nxt  = in_number;
          bcd_nxt  = '0;
          enc_nxt  = SH_W'(in_number);
          if (mode_decodes(in_mode)) begin
            cnt_nxt = CW'(VALUE_BITS - 1);
          end else begin
            cnt_nxt = dst_is_oct(in_mode) ? CW'(SH_W / 3 - 1) : CW'(SH_W - 1);
          end
        end
      end
      ST_DABBLE: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        if (cnt_r == '0) begin
          cnt_nxt = CW'(DIGITS - 1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_DECODE: begin
        bcd_nxt = {bcd_r[BCD_W-5:0], 4'h0};
        acc_nxt = dec_acc;
        if (dec_bad) begin
          bad_nxt = 1'b1;
        end else if (cnt_r == '0) begin
          enc_nxt = SH_W'(dec_acc);
          cnt_nxt = dst_is_oct(mode_r) ? CW'(SH_W / 3 - 1) : CW'(SH_W - 1);
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_ENCODE: begin
        enc_nxt = dst_is_oct(mode_r) ? {enc_r[SH_W-4:0], 3'b000}
                                     : {enc_r[SH_W-2:0], 1'b0};
        if (!ovf_r) begin
          if (cod_over) begin
            ovf_nxt = 1'b1;
          end else begin
            cod_nxt = cod_prod[VALUE_BITS-1:0];
          end
        end
        cnt_nxt = cnt_r - CW'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bad_nxt   = bad_r;
          out_ovf_nxt   = ovf_r;
          if (bad_r) begin
            out_result_nxt = '0;
          end else if (ovf_r) begin
            out_result_nxt = VAL_MAX;
          end else if (mode_encodes(mode_r)) begin
            out_result_nxt = cod_r;
          end else if (mode_decodes(mode_r)) begin
            out_result_nxt = acc_r;
          end else begin
            out_result_nxt = '0;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    cnt_r        <= cnt_nxt;
    bin_r        <= bin_nxt;
    bcd_r        <= bcd_nxt;
    acc_r        <= acc_nxt;
    enc_r        <= enc_nxt;
    cod_r        <= cod_nxt;
    bad_r        <= bad_nxt;
    ovf_r        <= ovf_nxt;
    out_result_r <= out_result_nxt;
    out_bad_r    <= out_bad_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result        = out_result_r;
  assign out_invalid_digit = out_bad_r;
  assign out_overflow      = out_ovf_r;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for radix_digit_converter_unit. Items go in through the
// valid/stall input channel in bursts with random gaps or back to back. The
// receiver stalls on a pattern of its own. Every converted number is predicted
// at the input transfer and compared field by field with the result, in order.
// ----------------------------------------------------------------------------
module testbench;
  import rdc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = 31;
  localparam logic [63:0] VAL_MAX = (64'd1 << VALUE_BITS) - 64'd1;
  localparam rdc_mode_t MODE_SPARE_LO = 3'd6;
  localparam rdc_mode_t MODE_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    rdc_mode_t             mode;
    logic [VALUE_BITS-1:0] number;
    logic [VALUE_BITS-1:0] result;
    logic                  invalid_digit;
    logic                  overflow;
  } conversion_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  rdc_mode_t             in_mode = MODE_BIN2VAL;
  logic [VALUE_BITS-1:0] in_number = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] out_result;
  logic                  out_invalid_digit;
  logic                  out_overflow;

  conversion_t expected_results[$];
  conversion_t want;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  int          stall_style = 0;
  int          stall_left = 0;

  radix_digit_converter_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result       (out_result),
    .out_invalid_digit(out_invalid_digit),
    .out_overflow     (out_overflow)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] digits_to_value(input logic [63:0] n, input logic [63:0] base,
                                                  output logic bad);
    logic [63:0] acc;
    logic [63:0] weight;
    logic [63:0] d;
    acc = 0;
    weight = 1;
    bad = 1'b0;
    while (n != 0) begin
      d = n % 10;
      if (d > base - 1) begin
        bad = 1'b1;
        return 0;
      end
      acc += d * weight;
      weight *= base;
      n /= 10;
    end
    return acc;
  endfunction

  function automatic logic [63:0] value_to_digits(input logic [63:0] v, input logic [63:0] base,
                                                  output logic ovf);
    logic [63:0] acc;
    logic [63:0] weight;
    logic [63:0] d;
    logic        weight_big;
    acc = 0;
    weight = 1;
    weight_big = 1'b0;
    ovf = 1'b0;
    while (v != 0) begin
      d = v % base;
      if (d != 0) begin
        if (weight_big || weight > (VAL_MAX - acc) / d) begin
          ovf = 1'b1;
          return VAL_MAX;
        end
        acc += d * weight;
      end
      v /= base;
      if (!weight_big) begin
        if (weight > VAL_MAX / 10) weight_big = 1'b1;
        else weight *= 10;
      end
    end
    return acc;
  endfunction

  function automatic conversion_t convert_expected(input rdc_mode_t mode,
                                                   input logic [VALUE_BITS-1:0] number);
    conversion_t c;
    logic [63:0] value;
    logic [63:0] res;
    logic        bad;
    logic        ovf;
    bad = 1'b0;
    ovf = 1'b0;
    res = 0;
    case (mode)
      MODE_BIN2VAL: res = digits_to_value(64'(number), 2, bad);
      MODE_VAL2BIN: res = value_to_digits(64'(number), 2, ovf);
      MODE_OCT2VAL: res = digits_to_value(64'(number), 8, bad);
      MODE_VAL2OCT: res = value_to_digits(64'(number), 8, ovf);
      MODE_BIN2OCT: begin
        value = digits_to_value(64'(number), 2, bad);
        if (!bad) res = value_to_digits(value, 8, ovf);
      end
      MODE_OCT2BIN: begin
        value = digits_to_value(64'(number), 8, bad);
        if (!bad) res = value_to_digits(value, 2, ovf);
      end
      default: res = 0;
    endcase
    c.mode = mode;
    c.number = number;
    c.result = res[VALUE_BITS-1:0];
    c.invalid_digit = bad;
    c.overflow = ovf;
    return c;
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_coded(input int base, input bit corrupt);
    logic [63:0] acc;
    int          ndig;
    int          pos;
    int          d;
    acc = 0;
    ndig = $urandom_range(1, 10);
    pos = corrupt ? $urandom_range(0, ndig - 1) : -1;
    for (int i = ndig - 1; i >= 0; i--) begin
      d = (i == pos) ? $urandom_range(base, 9) : $urandom_range(0, base - 1);
      acc = acc * 10 + 64'(d);
    end
    while (acc > VAL_MAX) acc = acc / 10;
    return acc[VALUE_BITS-1:0];
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    int          nb;
    logic [63:0] v;
    nb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, VALUE_BITS) : $urandom_range(1, 11);
    v = 64'($urandom()) & ((64'd1 << nb) - 64'd1);
    return v[VALUE_BITS-1:0];
  endfunction

  function automatic void report_field(input string field, input logic [63:0] exp_v,
                                       input logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: mode %0d number %0d expected %0d got %0d",
               field, want.mode, want.number, exp_v, got_v);
  endfunction

  task automatic send_item(input rdc_mode_t mode, input logic [VALUE_BITS-1:0] number);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_number <= number;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(convert_expected(mode, number));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic hold_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic test_zero_input();
    for (int m = 0; m < 8; m++) send_item(rdc_mode_t'(m), '0);
  endtask

  task automatic test_unused_modes();
    send_item(MODE_SPARE_LO, VAL_MAX[VALUE_BITS-1:0]);
    send_item(MODE_SPARE_HI, VAL_MAX[VALUE_BITS-1:0]);
  endtask

  task automatic test_extremes();
    send_item(MODE_BIN2VAL, 31'd1111111111);
    send_item(MODE_OCT2VAL, 31'd1777777777);
    send_item(MODE_VAL2BIN, 31'd1023);
    send_item(MODE_VAL2BIN, 31'd1024);
    send_item(MODE_VAL2BIN, VAL_MAX[VALUE_BITS-1:0]);
    send_item(MODE_VAL2OCT, 31'd268435455);
    send_item(MODE_VAL2OCT, VAL_MAX[VALUE_BITS-1:0]);
    send_item(MODE_BIN2OCT, 31'd1111111111);
    send_item(MODE_OCT2BIN, 31'd1777);
    send_item(MODE_OCT2BIN, 31'd2000);
  endtask

  task automatic test_invalid_digits();
    send_item(MODE_BIN2VAL, 31'd2);
    send_item(MODE_BIN2VAL, VAL_MAX[VALUE_BITS-1:0]);
    send_item(MODE_OCT2VAL, 31'd1777777778);
    send_item(MODE_BIN2OCT, 31'd1012);
    send_item(MODE_OCT2BIN, 31'd900000000);
  endtask

  task automatic send_random_items(input int count);
    rdc_mode_t mode;
    logic [VALUE_BITS-1:0] number;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        mode = rdc_mode_t'($urandom_range(0, 5));
        if (mode_decodes(mode))
          number = random_coded(src_is_oct(mode) ? 8 : 2, $urandom_range(0, 9) == 0);
        else
          number = random_value();
      end else begin
        mode = rdc_mode_t'($urandom_range(0, 7));
        number = VALUE_BITS'($urandom());
      end
      send_item(mode, number);
    end
  endtask

  task automatic test_random_traffic();
    gaps_on = 1'b1;
    send_random_items(1200);
  endtask

  task automatic test_drain_pause();
    send_random_items(20);
    hold_sender();
    wait (expected_results.size() == 0);
    send_random_items(80);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    send_random_items(400);
    gaps_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ((stall_left % 16) < 10);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: result %0d invalid_digit %0d overflow %0d",
                   out_result, out_invalid_digit, out_overflow);
      end else begin
        want = expected_results.pop_front();
        if (out_result !== want.result)
          report_field("result", 64'(want.result), 64'(out_result));
        if (out_invalid_digit !== want.invalid_digit)
          report_field("invalid_digit", 64'(want.invalid_digit), 64'(out_invalid_digit));
        if (out_overflow !== want.overflow)
          report_field("overflow", 64'(want.overflow), 64'(out_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_zero_input();
    test_unused_modes();
    test_extremes();
    test_invalid_digits();
    test_random_traffic();
    test_drain_pause();
    test_back_to_back();
    hold_sender();
    wait (expected_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
